/* rtl/ps2_keyboard_receiver_decoder_assert.svh */
// Assertion macros for the PS/2 keyboard receiver and decoder.
`ifndef PS2_KEYBOARD_RECEIVER_DECODER_ASSERT_SVH
`define PS2_KEYBOARD_RECEIVER_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define PS2KD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ps2kd assertion failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define PS2KD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ps2kd assertion failed");

`endif

/* rtl/ps2kd_pkg.sv */
// Shared constants and types for the PS/2 keyboard receiver and decoder.
package ps2kd_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

	localparam int         FRAME_W    = 4;
	localparam logic [3:0] FRAME_BITS = 4'd11;

	localparam logic [7:0] CODE_RELEASE = 8'hF0;
	localparam logic [7:0] CODE_EXTEND  = 8'hE0;
	localparam logic [7:0] CODE_LSHIFT  = 8'h12;
	localparam logic [7:0] CODE_RSHIFT  = 8'h59;
	localparam logic [7:0] CODE_F1      = 8'h05;

	localparam logic [1:0] CMD_EDGE      = 2'd0;
	localparam logic [1:0] CMD_MAP_WRITE = 2'd1;
	localparam logic [1:0] CMD_FIFO_READ = 2'd2;

	localparam logic [1:0] TBL_UNSHIFT = 2'd0;
	localparam logic [1:0] TBL_SHIFT   = 2'd1;
	localparam logic [1:0] TBL_EXT     = 2'd2;

	localparam int KMAP_TABLES = 3;
	localparam int KMAP_DEPTH  = KMAP_TABLES * 256;
	localparam int KMAP_AW     = 10;

	// Keymap lookup request raised by a completed frame.
	typedef struct packed {
		logic       lookup;
		logic [1:0] table_sel;
		logic [7:0] code;
	} lookup_t;

	// FIFO status after the item that leaves stage one.
	typedef struct packed {
		logic               popped;
		logic [COUNT_W-1:0] count;
		logic               ready;
	} fifo_stat_t;

endpackage

/* rtl/ps2_keyboard_receiver_decoder.sv */
// Top level of the PS/2 keyboard receiver, set 2 decoder and character FIFO.
// Stage one feeds the result stage; one item per cycle while res_stall is low,
// paced by the keymap read in stage one and the FIFO read into the result stage.
// Reset: asynchronous, active low; afterwards the keymap is cleared one entry a
// cycle over its 768 entries, during which no item is taken (register writes still are).
`include "ps2_keyboard_receiver_decoder_assert.svh"

module ps2_keyboard_receiver_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// event channel
	input  logic                          evt_valid,
	output logic                          evt_stall,
	input  logic [1:0]                    command,
	input  logic                          data_line,
	input  logic [1:0]                    table_select,
	input  logic [7:0]                    map_scan_code,
	input  logic [7:0]                    map_character,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          read_valid,
	output logic [7:0]                    read_char,
	output logic [ps2kd_pkg::COUNT_W-1:0] fifo_count,
	output logic                          char_ready,
	// capture enable register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);
	import ps2kd_pkg::*;

	// Keymap: three tables of 256 entries, each a valid bit and a character.
	logic [8:0]         kmap_mem [KMAP_DEPTH];
	logic [KMAP_AW-1:0] clr_idx_q;
	logic               clearing_q;

	logic capture_enable_q;

	// Pipeline state
	logic       v1_q;
	logic       lookup_s1;
	logic       pop_s1;
	logic [8:0] kmap_rd_s1;
	logic       v2_q;
	logic       read_valid_s2;
	logic [COUNT_W-1:0] count_s2;
	logic       ready_s2;

	logic       accept;
	logic       en1;
	logic       en2;
	logic       step;
	logic       is_edge;
	logic       is_map_write;
	logic       is_read;
	lookup_t    req;
	fifo_stat_t stat;
	logic [7:0] fifo_rd_data;

	// Stage enables: a stage moves on when the one after it is empty or moving.
	assign en2       = !v2_q || !res_stall;
	assign en1       = !v1_q || en2;
	assign evt_stall = clearing_q || !en1;
	assign accept    = evt_valid && !evt_stall;
	assign step      = v1_q && en2;

	assign cfg_ready = 1'b1;

	always_comb begin
		is_edge      = 1'b0;
		is_map_write = 1'b0;
		is_read      = 1'b0;
		unique case (command)
			CMD_EDGE:      is_edge      = 1'b1;
			CMD_MAP_WRITE: is_map_write = 1'b1;
			CMD_FIFO_READ: is_read      = 1'b1;
			default:       ;
		endcase
	end

	// Frame assembly and shift / extended / release flags; flags settle at acceptance.
	ps2kd_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_en   (accept && is_edge),
		.data_line (data_line),
		.req       (req)
	);

	// Keymap port: the clearing sweep owns the write port until done. A map write
	// and a lookup come from different items, so they never share a cycle and a
	// lookup in the cycle after a write already sees the new entry.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			kmap_mem[clr_idx_q] <= '0;
		end else if (accept && is_map_write && table_select <= TBL_EXT) begin
			kmap_mem[{table_select, map_scan_code}] <= {1'b1, map_character};
		end
		// read data holds while stage one waits
		if (accept) begin
			kmap_rd_s1 <= kmap_mem[{req.table_sel, req.code}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + KMAP_AW'(1);
			if (clr_idx_q == KMAP_AW'(KMAP_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			capture_enable_q <= cfg_data;
		end
	end

	// Stage one: keymap data arrives; push or pop is settled as the item leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (en1) begin
			v1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_s1 <= req.lookup && is_edge;
			pop_s1    <= is_read;
		end
	end

	// FIFO pushes and pops happen one item at a time in stage one, so an entry
	// written in one cycle is in memory before any later pop reads it.
	ps2kd_char_fifo u_char_fifo (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.push_req       (lookup_s1 && kmap_rd_s1[8]),
		.pop_req        (pop_s1),
		.capture_enable (capture_enable_q),
		.push_char      (kmap_rd_s1[7:0]),
		.stat           (stat),
		.rd_data        (fifo_rd_data)
	);

	// Stage two: result register, FIFO read data joins here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (en2) begin
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			read_valid_s2 <= stat.popped;
			count_s2      <= stat.count;
			ready_s2      <= stat.ready;
		end
	end

	assign res_valid  = v2_q;
	assign read_valid = read_valid_s2;
	assign read_char  = read_valid_s2 ? fifo_rd_data : 8'd0;
	assign fifo_count = count_s2;
	assign char_ready = ready_s2;

	// Checks
	`PS2KD_ASSERT_NEXT(a_accept_fills_s1, accept, v1_q)
	`PS2KD_ASSERT_IMPL(a_count_bound, res_valid, fifo_count <= COUNT_W'(FIFO_DEPTH))
	`PS2KD_ASSERT_IMPL(a_pop_clears_ready, res_valid && read_valid, !char_ready)
	`PS2KD_ASSERT_IMPL(a_no_pipe_during_clear, clearing_q, !v1_q && !v2_q)

endmodule

/* rtl/ps2kd_decoder.sv */
// PS/2 frame assembly and scan-code flag decoding.
module ps2kd_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                edge_en,
	input  logic                data_line,
	output ps2kd_pkg::lookup_t  req
);
	import ps2kd_pkg::*;

	logic               expect_rising_q;
	logic [FRAME_W-1:0] frame_count_q;
	logic [7:0]         shift_in_q;
	logic               release_q;
	logic               shift_held_q;
	logic               extended_q;

	logic [FRAME_W-1:0] frame_dec;
	logic               decode_now;
	logic               is_shift;
	logic               is_flag_code;

	assign frame_dec    = frame_count_q - FRAME_W'(1);
	assign decode_now   = expect_rising_q && (frame_dec == '0);
	assign is_shift     = (shift_in_q == CODE_LSHIFT) || (shift_in_q == CODE_RSHIFT);
	assign is_flag_code = is_shift || (shift_in_q == CODE_RELEASE) ||
		(shift_in_q == CODE_EXTEND) || (shift_in_q == CODE_F1);

	always_comb begin
		req.lookup = decode_now && !release_q && !is_flag_code;
		req.code   = shift_in_q;
		if (shift_held_q) begin
			req.table_sel = TBL_SHIFT;
		end else if (extended_q) begin
			req.table_sel = TBL_EXT;
		end else begin
			req.table_sel = TBL_UNSHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_rising_q <= 1'b0;
			frame_count_q   <= FRAME_BITS;
			shift_in_q      <= '0;
			release_q       <= 1'b0;
			shift_held_q    <= 1'b0;
			extended_q      <= 1'b0;
		end else if (edge_en) begin
			if (!expect_rising_q) begin
				// data bits sit between the start bit and parity
				if (frame_count_q < FRAME_BITS && frame_count_q > FRAME_W'(2)) begin
					shift_in_q <= {data_line, shift_in_q[7:1]};
				end
				expect_rising_q <= 1'b1;
			end else begin
				expect_rising_q <= 1'b0;
				frame_count_q   <= decode_now ? FRAME_BITS : frame_dec;
				if (decode_now) begin
					if (!release_q) begin
						if (shift_in_q == CODE_RELEASE) begin
							release_q  <= 1'b1;
							extended_q <= 1'b0;
						end else if (is_shift) begin
							shift_held_q <= 1'b1;
						end else if (shift_in_q == CODE_EXTEND) begin
							extended_q <= 1'b1;
						end
					end else begin
						release_q <= 1'b0;
						if (is_shift) begin
							shift_held_q <= 1'b0;
						end else if (shift_in_q == CODE_EXTEND) begin
							extended_q <= 1'b0;
						end
					end
				end
			end
		end
	end

endmodule

/* rtl/ps2kd_char_fifo.sv */
// Character FIFO: storage memory, indices, fill count and ready flag.
module ps2kd_char_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   push_req,
	input  logic                   pop_req,
	input  logic                   capture_enable,
	input  logic [7:0]             push_char,
	output ps2kd_pkg::fifo_stat_t  stat,
	output logic [7:0]             rd_data
);
	import ps2kd_pkg::*;

	logic [7:0]         mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_idx_q;
	logic [FIFO_AW-1:0] rd_idx_q;
	logic [COUNT_W-1:0] count_q;
	logic               ready_q;
	logic [7:0]         rd_data_q;

	logic push;
	logic pop;

	assign push = step && push_req && capture_enable && (count_q < COUNT_W'(FIFO_DEPTH));
	assign pop  = step && pop_req && (count_q != '0);

	always_comb begin
		stat.popped = pop;
		stat.count  = count_q;
		stat.ready  = ready_q;
		if (push) begin
			stat.count = count_q + COUNT_W'(1);
			stat.ready = 1'b1;
		end else if (pop) begin
			stat.count = count_q - COUNT_W'(1);
			stat.ready = 1'b0;
		end
	end

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_idx_q] <= push_char;
		end
		if (pop) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
			ready_q  <= 1'b0;
		end else begin
			count_q <= stat.count;
			ready_q <= stat.ready;
			if (push) begin
				wr_idx_q <= (wr_idx_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_idx_q <= (rd_idx_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_q + FIFO_AW'(1);
			end
		end
	end

endmodule

/* tb/tb_ps2_keyboard_receiver_decoder.sv */
// Self-checking testbench for the PS/2 keyboard receiver, set 2 decoder and character FIFO.
`timescale 1ns / 100ps

module tb_ps2_keyboard_receiver_decoder;

	import ps2kd_pkg::*;

	// Command code the block ignores; the package names only the three live ones.
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam int SETTLE_CYCLES  = 4;     // covers stage one and the result stage, plus margin
	localparam int TAIL_CYCLES    = 8;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;  // covers the keymap clear and the long hold

	// Codes that get entries in all three tables before the random traffic.
	localparam logic [7:0] KEY_CODES [8] = '{8'h1C, 8'h32, 8'h21, 8'h23,
		8'h24, 8'h2B, 8'h00, 8'hFF};

	typedef struct packed {
		logic               read_valid;
		logic [7:0]         read_char;
		logic [COUNT_W-1:0] fifo_count;
		logic               char_ready;
	} status_t;

	logic               clk;
	logic               arst_n;
	logic               evt_valid;
	logic               evt_stall;
	logic [1:0]         command;
	logic               data_line;
	logic [1:0]         table_select;
	logic [7:0]         map_scan_code;
	logic [7:0]         map_character;
	logic               res_valid;
	logic               res_stall;
	logic               read_valid;
	logic [7:0]         read_char;
	logic [COUNT_W-1:0] fifo_count;
	logic               char_ready;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;

	// Decoder state mirrored by the testbench.
	logic       capture_on;
	logic       want_rising;
	logic [3:0] bits_left;
	logic [7:0] frame_shift;
	logic       break_pending;
	logic       shift_down;
	logic       ext_prefix;
	logic [8:0] keymap_copy [KMAP_TABLES][256];
	logic [7:0] held_chars [$];
	logic       ready_copy;

	// Status items owed by the block, oldest first.
	status_t owed_status [$];

	int  fail_count;
	int  items_sent;
	int  long_hold_req;
	bit  tx_gaps_on;
	bit  rx_gaps_on;
	bit  result_taken;

	ps2_keyboard_receiver_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (evt_valid),
		.evt_stall     (evt_stall),
		.command       (command),
		.data_line     (data_line),
		.table_select  (table_select),
		.map_scan_code (map_scan_code),
		.map_character (map_character),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.read_valid    (read_valid),
		.read_char     (read_char),
		.fifo_count    (fifo_count),
		.char_ready    (char_ready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out the status item that one accepted event produces and advance the
	// mirrored state. Edges alternate falling/rising; the eight data bits arrive
	// on the falling edges while the frame count is between ten and three, and
	// the code is decoded when the eleventh rising edge brings the count to zero.
	function automatic status_t event_status(input logic [1:0] cmd, input logic level,
			input logic [1:0] sel, input logic [7:0] code, input logic [7:0] chr);
		status_t    st;
		logic [1:0] tbl;
		logic [8:0] entry;
		st = '0;
		case (cmd)
			CMD_EDGE: begin
				if (!want_rising) begin
					if (bits_left < FRAME_BITS && bits_left > 4'd2)
						frame_shift = {level, frame_shift[7:1]};
					want_rising = 1'b1;
				end else begin
					want_rising = 1'b0;
					bits_left   = bits_left - 4'd1;
					if (bits_left == 4'd0) begin
						bits_left = FRAME_BITS;
						if (!break_pending) begin
							if (frame_shift == CODE_RELEASE) begin
								// break prefix also drops any extended prefix
								break_pending = 1'b1;
								ext_prefix    = 1'b0;
							end else if (frame_shift == CODE_LSHIFT ||
									frame_shift == CODE_RSHIFT) begin
								shift_down = 1'b1;
							end else if (frame_shift == CODE_EXTEND) begin
								ext_prefix = 1'b1;
							end else if (frame_shift != CODE_F1) begin
								// shift wins over extended; extended stays set after the lookup
								tbl   = shift_down ? TBL_SHIFT :
									(ext_prefix ? TBL_EXT : TBL_UNSHIFT);
								entry = keymap_copy[tbl][frame_shift];
								// drop the character on a miss, a full FIFO or capture off
								if (entry[8] && capture_on && held_chars.size() < FIFO_DEPTH) begin
									held_chars.push_back(entry[7:0]);
									ready_copy = 1'b1;
								end
							end
						end else begin
							// released key: only shift and extended releases matter
							break_pending = 1'b0;
							if (frame_shift == CODE_LSHIFT || frame_shift == CODE_RSHIFT)
								shift_down = 1'b0;
							else if (frame_shift == CODE_EXTEND)
								ext_prefix = 1'b0;
						end
					end
				end
			end
			CMD_MAP_WRITE: begin
				// a table select beyond the extended table is ignored
				if (sel <= TBL_EXT)
					keymap_copy[sel][code] = {1'b1, chr};
			end
			CMD_FIFO_READ: begin
				// an empty FIFO leaves everything alone, ready flag included
				if (held_chars.size() != 0) begin
					st.read_valid = 1'b1;
					st.read_char  = held_chars.pop_front();
					ready_copy    = 1'b0;
				end
			end
			default: ;
		endcase
		st.fifo_count = COUNT_W'(held_chars.size());
		st.char_ready = ready_copy;
		return st;
	endfunction

	// Offer one item after a random gap, hold it until accepted, then log what it owes.
	task automatic send_item(input logic [1:0] cmd, input logic level, input logic [1:0] sel,
			input logic [7:0] code, input logic [7:0] chr);
		int   gap;
		logic stalled;
		gap = tx_gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid     <= 1'b1;
		command       <= cmd;
		data_line     <= level;
		table_select  <= sel;
		map_scan_code <= code;
		map_character <= chr;
		// stall is sampled mid-cycle, where it is settled for the coming edge
		do begin
			@(negedge clk);
			stalled = evt_stall;
			@(posedge clk);
		end while (stalled);
		owed_status.push_back(event_status(cmd, level, sel, code, chr));
		items_sent++;
	endtask

	// Clock edge with random contents in the fields the block ignores for edges.
	task automatic send_edge(input logic level);
		send_item(CMD_EDGE, level, 2'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic pop_request();
		send_item(CMD_FIFO_READ, 1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic map_key(input logic [1:0] sel, input logic [7:0] code, input logic [7:0] chr);
		send_item(CMD_MAP_WRITE, 1'($urandom), sel, code, chr);
	endtask

	// Full eleven-bit frame: start, eight data bits LSB first, odd parity, stop.
	// Data is carried on the falling edge; the rising edge level is don't-care.
	task automatic send_scan_code(input logic [7:0] code);
		logic [10:0] frame;
		frame = {1'b1, ~^code, code, 1'b0};
		for (int i = 0; i < 11; i++) begin
			send_edge(frame[i]);
			send_edge(1'($urandom));
		end
	endtask

	// Frame cut short at a random point and padded with garbage, so the
	// frame count stays aligned while the decoded code is mangled.
	task automatic send_broken_frame();
		int cut;
		cut = $urandom_range(1, 21);
		for (int i = 0; i < 22; i++) begin
			if (i < cut && i[0] == 1'b0)
				send_edge(1'b0);
			else
				send_edge(1'($urandom));
		end
	endtask

	// Drop valid and wait until every owed item has come back and the pipeline is empty.
	task automatic settle_block();
		evt_valid <= 1'b0;
		while (owed_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capture(input logic enable);
		logic taken;
		settle_block();
		cfg_valid <= 1'b1;
		cfg_data  <= enable;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid  <= 1'b0;
		capture_on = enable;
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 9))
			0:       return CODE_RELEASE;
			1:       return CODE_EXTEND;
			2:       return $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
			3:       return CODE_F1;
			4:       return 8'($urandom);
			default: return KEY_CODES[$urandom_range(0, 7)];
		endcase
	endfunction

	// Empty read, ignored command, ignored table select, and keymap writes at the field extremes.
	task automatic test_status_only();
		pop_request();
		send_item(CMD_NONE, 1'b1, 2'd3, 8'hFF, 8'hFF);
		send_item(CMD_NONE, 1'b0, 2'd0, 8'h00, 8'h00);
		map_key(2'd3, 8'h1C, 8'hEE);
		map_key(TBL_UNSHIFT, 8'h00, 8'hFF);
		map_key(TBL_EXT, 8'hFF, 8'h00);
		map_key(TBL_UNSHIFT, 8'h1C, 8'h61);
		map_key(TBL_SHIFT, 8'h1C, 8'h41);
		map_key(TBL_EXT, 8'h1C, 8'h80);
		pop_request();
	endtask

	// Capture off: a mapped make code is decoded but its character is dropped.
	task automatic test_capture_disabled();
		write_capture(1'b0);
		send_scan_code(8'h1C);
		pop_request();
	endtask

	task automatic test_scan_decoding();
		write_capture(1'b1);
		// plain make code, then a read that empties the FIFO and one that finds it empty
		send_scan_code(8'h1C);
		pop_request();
		pop_request();
		// left and right shift select the shifted table; releases clear them
		send_scan_code(CODE_LSHIFT);
		send_scan_code(8'h1C);
		send_scan_code(CODE_RELEASE);
		send_scan_code(CODE_LSHIFT);
		send_scan_code(CODE_RSHIFT);
		send_scan_code(8'h1C);
		send_scan_code(CODE_RELEASE);
		send_scan_code(CODE_RSHIFT);
		// extended prefix holds across two lookups until its release
		send_scan_code(CODE_EXTEND);
		send_scan_code(8'h1C);
		send_scan_code(8'hFF);
		send_scan_code(CODE_RELEASE);
		send_scan_code(CODE_EXTEND);
		// shift takes priority over extended
		send_scan_code(CODE_EXTEND);
		send_scan_code(CODE_LSHIFT);
		send_scan_code(8'h1C);
		send_scan_code(CODE_RELEASE);
		send_scan_code(CODE_LSHIFT);
		// break after extended clears it and the released key is ignored
		send_scan_code(CODE_EXTEND);
		send_scan_code(CODE_RELEASE);
		send_scan_code(8'h1C);
		// F1 does nothing; an unmapped code misses; code zero hits the unshifted table
		send_scan_code(CODE_F1);
		send_scan_code(8'h33);
		send_scan_code(8'h00);
		repeat (6) pop_request();
	endtask

	// Push past the FIFO depth, then read it dry and beyond.
	task automatic test_fifo_full();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		for (int i = 0; i < FIFO_DEPTH + 2; i++)
			send_scan_code(i[0] ? 8'h1C : 8'h00);
		repeat (FIFO_DEPTH + 3) pop_request();
		settle_block();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering items.
	task automatic test_back_pressure();
		tx_gaps_on    = 1'b0;
		long_hold_req = LONG_HOLD;
		send_scan_code(8'h1C);
		for (int i = 0; i < 30; i++) begin
			if (i[1:0] == 2'd0)
				map_key(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
			else
				pop_request();
		end
		// sender pauses until every owed item has arrived
		settle_block();
	endtask

	task automatic test_random_traffic();
		int start_count;
		int pick;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		write_capture(1'b1);
		foreach (KEY_CODES[k])
			for (int t = 0; t < KMAP_TABLES; t++)
				map_key(2'(t), KEY_CODES[k], 8'($urandom));
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			// new phase now and then: capture setting and idling pattern
			if ($urandom_range(0, 14) == 0) begin
				write_capture(1'($urandom_range(0, 1)));
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_scan_code(pick_code());
			else if (pick < 75)
				pop_request();
			else if (pick < 85)
				map_key(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
			else if (pick < 90)
				map_key(2'($urandom_range(0, 2)), KEY_CODES[$urandom_range(0, 7)],
					8'($urandom));
			else if (pick < 95)
				send_broken_frame();
			else
				send_item(CMD_NONE, 1'($urandom), 2'($urandom), 8'($urandom),
					8'($urandom));
		end
		settle_block();
	endtask

	// Result side: draw a stall per item, or take a long hold when one is requested.
	initial begin
		int stall_left;
		stall_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req != 0) begin
				stall_left    = long_hold_req;
				long_hold_req = 0;
			end else if (result_taken) begin
				stall_left = rx_gaps_on ? $urandom_range(0, 16) : 0;
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each result taken at the coming edge against the oldest owed item.
	always @(negedge clk) begin
		status_t want;
		result_taken = 1'b0;
		if (arst_n && res_valid && !res_stall) begin
			result_taken = 1'b1;
			if (owed_status.size() == 0) begin
				$error("result item with nothing owed");
				fail_count++;
			end else begin
				want = owed_status.pop_front();
				check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
				check_field("read_char", want.read_char, read_char);
				check_field("fifo_count", 8'(want.fifo_count), 8'(fifo_count));
				check_field("char_ready", 8'(want.char_ready), 8'(char_ready));
			end
		end
	end

	// Watchdog: end the run after too long without any handshake completing.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_ps2_keyboard_receiver_decoder: errors");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		evt_valid     <= 1'b0;
		command       <= CMD_EDGE;
		data_line     <= 1'b0;
		table_select  <= TBL_UNSHIFT;
		map_scan_code <= 8'h00;
		map_character <= 8'h00;
		cfg_valid     <= 1'b0;
		cfg_data      <= 1'b0;
		// mirrored state starts at its reset values
		capture_on    = 1'b0;
		want_rising   = 1'b0;
		bits_left     = FRAME_BITS;
		frame_shift   = 8'h00;
		break_pending = 1'b0;
		shift_down    = 1'b0;
		ext_prefix    = 1'b0;
		ready_copy    = 1'b0;
		foreach (keymap_copy[t, c])
			keymap_copy[t][c] = '0;
		fail_count    = 0;
		items_sent    = 0;
		long_hold_req = 0;
		tx_gaps_on    = 1'b1;
		rx_gaps_on    = 1'b1;
		result_taken  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_status_only();
		test_capture_disabled();
		test_scan_decoding();
		test_fifo_full();
		test_back_pressure();
		test_random_traffic();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && owed_status.size() == 0)
			$display("tb_ps2_keyboard_receiver_decoder: clean");
		else
			$display("tb_ps2_keyboard_receiver_decoder: errors");
		$finish;
	end

endmodule

/* ps2_keyboard_receiver_decoder.f */
+incdir+rtl
rtl/ps2kd_pkg.sv
rtl/ps2kd_decoder.sv
rtl/ps2kd_char_fifo.sv
rtl/ps2_keyboard_receiver_decoder.sv
tb/tb_ps2_keyboard_receiver_decoder.sv
